FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

FILE: hw/rtl/bta_pkg.sv
package bta_pkg;

	typedef logic       cmd_t;
	typedef logic [4:0] requester_t;
	typedef logic [1:0] status_t;
	typedef logic [15:0] out_ticket_t;

	localparam cmd_t CMD_REQUEST = 1'b0;
	localparam cmd_t CMD_RELEASE = 1'b1;

	localparam status_t STATUS_OK        = 2'd0;
	localparam status_t STATUS_IGNORED   = 2'd1;
	localparam status_t STATUS_SATURATED = 2'd2;

	// register map
	localparam int unsigned REG_ACTIVE  = 0;
	localparam int unsigned PADDR_W     = 2;
	localparam int unsigned ACTIVE_W    = 6;
	localparam logic [5:0]  ACTIVE_RST  = 6'd32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_FINISH
	} bta_state_t;

endpackage

FILE: hw/rtl/bta_if.sv
interface bta_req_if;
	logic                  valid;
	logic                  ready;
	bta_pkg::cmd_t         cmd;
	bta_pkg::requester_t   requester;

	modport source (output valid, output cmd, output requester, input ready);
	modport sink   (input valid, input cmd, input requester, output ready);
endinterface

interface bta_res_if;
	logic                  valid;
	logic                  ready;
	bta_pkg::status_t      status;
	bta_pkg::out_ticket_t  ticket;
	logic                  holder_valid;
	bta_pkg::requester_t   holder;
	bta_pkg::out_ticket_t  holder_ticket;

	modport source (output valid, output status, output ticket, output holder_valid,
		output holder, output holder_ticket, input ready);
	modport sink   (input valid, input status, input ticket, input holder_valid,
		input holder, input holder_ticket, output ready);
endinterface

FILE: hw/rtl/bakery_ticket_arbiter.sv
// Bakery ticket arbiter. Each word on req_ch is a request or release from one
// requester; each produces one word on res_ch with the issuer's new ticket and
// the current holder (smallest nonzero ticket, lower index on ties). Tickets
// live in a single-port synchronous RAM with a registered read; one step
// makes a single pass over the n active entries, one entry per cycle, finding
// the largest ticket and the smallest other ticket together, then writes the
// issuer's entry back; n is the clamped active requester count.
// The next word is taken as soon as the result is in the output register.
// The RAM needs no clearing pass: per-entry valid bits, cleared by reset,
// make an unwritten entry read as zero.
`include "assert_macros.svh"

module bakery_ticket_arbiter #(
	parameter int MAX_REQUESTERS = 32,
	parameter int TICKET_WIDTH   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bta_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	bta_req_if.sink                       req_ch,
	bta_res_if.source                     res_ch
);

	localparam int IW   = $clog2(MAX_REQUESTERS);
	localparam int TW   = TICKET_WIDTH;
	localparam int NCAP = (MAX_REQUESTERS < 63) ? MAX_REQUESTERS : 63;
	localparam logic [TW-1:0] TOP = {TW{1'b1}};

	// config
	logic [5:0] active_q;
	logic       cfg_we;
	logic [5:0] n;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite &&
		(32'(paddr >> 2) == 32'(bta_pkg::REG_ACTIVE));
	assign prdata = (32'(paddr >> 2) == 32'(bta_pkg::REG_ACTIVE)) ? {26'd0, active_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= bta_pkg::ACTIVE_RST;
		end else if (cfg_we) begin
			active_q <= pwdata[5:0];
		end
	end

	always_comb begin
		if (active_q == 6'd0) begin
			n = 6'd1;
		end else if (active_q > 6'(NCAP)) begin
			n = 6'(NCAP);
		end else begin
			n = active_q;
		end
	end

	// control
	bta_pkg::bta_state_t state_q, state_d;
	logic       accept, scan_en, last_issue, out_load, fin_en;

	logic [5:0] k_q;
	logic       vld_s1;
	logic [5:0] k_s1;
	logic [TW-1:0] rd_s1;

	bta_pkg::cmd_t       cmd_q;
	bta_pkg::requester_t who_q;
	logic [TW-1:0] max_q;
	logic [TW-1:0] min_q;
	logic [5:0]    idx_q;
	logic          found_q;

	logic [MAX_REQUESTERS-1:0] valid_q;
	logic [TW-1:0] mem [MAX_REQUESTERS];

	assign accept     = req_ch.valid && req_ch.ready;
	assign last_issue = (k_q == n - 6'd1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bta_pkg::ST_IDLE:   if (req_ch.valid) state_d = bta_pkg::ST_SCAN;
			bta_pkg::ST_SCAN:   if (last_issue) state_d = bta_pkg::ST_LAST;
			bta_pkg::ST_LAST:   state_d = bta_pkg::ST_FINISH;
			bta_pkg::ST_FINISH: if (!res_ch.valid || res_ch.ready) state_d = bta_pkg::ST_IDLE;
			default:            state_d = bta_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ch.ready = 1'b0;
		scan_en      = 1'b0;
		fin_en       = 1'b0;
		unique case (state_q)
			bta_pkg::ST_IDLE:   req_ch.ready = 1'b1;
			bta_pkg::ST_SCAN:   scan_en = 1'b1;
			bta_pkg::ST_LAST:   scan_en = 1'b0;
			bta_pkg::ST_FINISH: fin_en = 1'b1;
			default:            req_ch.ready = 1'b0;
		endcase
	end

	assign out_load = fin_en && (!res_ch.valid || res_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bta_pkg::ST_IDLE;
			vld_s1  <= 1'b0;
			k_q     <= 6'd0;
		end else begin
			state_q <= state_d;
			vld_s1  <= scan_en;
			if (accept) begin
				k_q <= 6'd0;
			end else if (scan_en) begin
				k_q <= k_q + 6'd1;
			end
		end
	end

	// finish: new ticket and holder
	logic               ignored;
	logic [TW:0]        sum;
	logic [TW-1:0]      new_t;
	bta_pkg::status_t   status_d;
	logic               hv_d;
	logic [5:0]         hidx_d;
	logic [TW-1:0]      ht_d;
	logic               mem_we;

	assign ignored = ({1'b0, who_q} >= n);
	assign sum     = {1'b0, max_q} + (TW+1)'(1);

	always_comb begin
		new_t    = '0;
		status_d = bta_pkg::STATUS_OK;
		hv_d     = found_q;
		hidx_d   = found_q ? idx_q : 6'd0;
		ht_d     = found_q ? min_q : '0;
		if (ignored) begin
			status_d = bta_pkg::STATUS_IGNORED;
		end else if (cmd_q == bta_pkg::CMD_REQUEST) begin
			if (sum[TW]) begin
				new_t    = TOP;
				status_d = bta_pkg::STATUS_SATURATED;
			end else begin
				new_t = sum[TW-1:0];
			end
			// new ticket is never below the others; it only wins when alone
			// or on a saturated tie with a higher-index entry
			if (!(found_q && (min_q < new_t || (min_q == new_t && idx_q < {1'b0, who_q})))) begin
				hv_d   = 1'b1;
				hidx_d = {1'b0, who_q};
				ht_d   = new_t;
			end
		end
	end

	assign mem_we = out_load && !ignored;

	// ticket RAM: write only in finish, read only while scanning
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[IW'(who_q)] <= new_t;
		end else if (scan_en) begin
			rd_s1 <= mem[IW'(k_q)];
		end
		k_s1 <= k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (mem_we) begin
			valid_q[IW'(who_q)] <= 1'b1;
		end
	end

	// scan accumulators
	logic [TW-1:0] t_s1;
	assign t_s1 = valid_q[IW'(k_s1)] ? rd_s1 : '0;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= req_ch.cmd;
			who_q   <= req_ch.requester;
			max_q   <= '0;
			found_q <= 1'b0;
			min_q   <= '0;
			idx_q   <= 6'd0;
		end else if (vld_s1) begin
			if (t_s1 > max_q) begin
				max_q <= t_s1;
			end
			// strict compare in index order keeps the lower index on ties
			if (k_s1 != {1'b0, who_q} && t_s1 != '0 && (!found_q || t_s1 < min_q)) begin
				found_q <= 1'b1;
				min_q   <= t_s1;
				idx_q   <= k_s1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.valid <= 1'b0;
		end else if (out_load) begin
			res_ch.valid <= 1'b1;
		end else if (res_ch.ready) begin
			res_ch.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_ch.status        <= status_d;
			res_ch.ticket        <= 16'(new_t);
			res_ch.holder_valid  <= hv_d;
			res_ch.holder        <= 5'(hidx_d);
			res_ch.holder_ticket <= 16'(ht_d);
		end
	end

	`ASSERT_NEVER(a_scan_in_range, clk, arst_n, scan_en && (k_q >= n))
	`ASSERT_ALWAYS(a_load_shows, clk, arst_n, out_load |=> res_ch.valid)
	`ASSERT_ALWAYS(a_sat_top, clk, arst_n, (res_ch.valid && res_ch.status == bta_pkg::STATUS_SATURATED) |-> (res_ch.ticket == 16'(TOP)))
	`ASSERT_ALWAYS(a_no_holder_zero, clk, arst_n, (res_ch.valid && !res_ch.holder_valid) |-> (res_ch.holder == 5'd0 && res_ch.holder_ticket == 16'd0))
	`ASSERT_NEVER(a_write_idle_only, clk, arst_n, mem_we && scan_en)

endmodule

FILE: sim/tb_bakery_ticket_arbiter.sv
typedef struct packed {
	bta_pkg::status_t     status;
	bta_pkg::out_ticket_t ticket;
	logic                 holder_valid;
	bta_pkg::requester_t  holder;
	bta_pkg::out_ticket_t holder_ticket;
} grant_word_t;

// Shadow of the ticket store plus the queue of grant words still owed by the block.
class ticket_book;
	localparam int unsigned SLOTS      = 32;
	localparam int unsigned TICKET_TOP = 16'hFFFF;

	logic [15:0] tickets [SLOTS];
	logic [5:0]  active_reg;
	grant_word_t pending_grants [$];
	int unsigned mismatches;

	function new();
		foreach (tickets[k])
			tickets[k] = '0;
		active_reg = bta_pkg::ACTIVE_RST;
		mismatches = 0;
	endfunction

	function int unsigned live_count();
		int unsigned n;
		n = active_reg;
		if (n < 1)
			n = 1;
		if (n > SLOTS)
			n = SLOTS;
		return n;
	endfunction

	// Apply one accepted command to the shadow store and queue the grant it yields.
	function void note_word(bta_pkg::cmd_t cmd, bta_pkg::requester_t who);
		int unsigned n, top, next, k;
		grant_word_t w;
		n = live_count();
		w = '0;
		if (who >= n) begin
			w.status = bta_pkg::STATUS_IGNORED;
		end else if (cmd == bta_pkg::CMD_REQUEST) begin
			top = 0;
			for (k = 0; k < n; k++)
				if (tickets[k] > top)
					top = tickets[k];
			next = top + 1;
			if (next > TICKET_TOP) begin
				next = TICKET_TOP;
				w.status = bta_pkg::STATUS_SATURATED;
			end
			tickets[who] = next[15:0];
			w.ticket = next[15:0];
		end else begin
			tickets[who] = '0;
		end
		// smallest nonzero ticket wins, strict compare keeps the lower index on ties
		for (k = 0; k < n; k++) begin
			if (tickets[k] != 0 && (!w.holder_valid || tickets[k] < w.holder_ticket)) begin
				w.holder_valid = 1'b1;
				w.holder = k[4:0];
				w.holder_ticket = tickets[k];
			end
		end
		pending_grants.push_back(w);
	endfunction

	function void check_word(grant_word_t got);
		grant_word_t want;
		logic [15:0] want_f [5];
		logic [15:0] got_f [5];
		string names [5];
		int k;
		names = '{"status", "ticket", "holder_valid", "holder", "holder_ticket"};
		if (pending_grants.size() == 0) begin
			mismatches++;
			$display("%0t: grant word with none expected: %p", $time, got);
			return;
		end
		want = pending_grants.pop_front();
		want_f = '{want.status, want.ticket, want.holder_valid, want.holder,
			want.holder_ticket};
		got_f = '{got.status, got.ticket, got.holder_valid, got.holder, got.holder_ticket};
		for (k = 0; k < 5; k++) begin
			if (got_f[k] !== want_f[k]) begin
				mismatches++;
				$display("%0t: %s expected %0d actual %0d", $time, names[k],
					want_f[k], got_f[k]);
			end
		end
	endfunction
endclass

module tb_bakery_ticket_arbiter;

	localparam int unsigned SETTLE_CYCLES = 40;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [bta_pkg::PADDR_W-1:0] paddr;
	logic [31:0]                 pwdata;
	logic [31:0]                 prdata;
	logic                        pready;

	bta_req_if req_if ();
	bta_res_if res_if ();

	ticket_book book;
	int unsigned send_idle_pct;
	int unsigned stall_pct;

	bakery_ticket_arbiter u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req_ch  (req_if),
		.res_ch  (res_if)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 5_000_000);
		$display("*** FAILED ***");
		$finish;
	end

	// receiver back-pressure
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_if.ready = !(stall_pct > 0 && $urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			book.check_word('{res_if.status, res_if.ticket, res_if.holder_valid,
				res_if.holder, res_if.holder_ticket});
	end

	task automatic set_idling(input int mode);
		case (mode)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle_pct = 72;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 72;
			end
			default: begin
				send_idle_pct = 11;
				stall_pct = 11;
			end
		endcase
	endtask

	// Called just after a falling edge; leaves valid high for a back-to-back word.
	task automatic send_word(input bta_pkg::cmd_t cmd, input bta_pkg::requester_t who);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req_if.valid = 1'b0;
			@(negedge clk);
		end
		req_if.valid = 1'b1;
		req_if.cmd = cmd;
		req_if.requester = who;
		do
			@(posedge clk);
		while (!req_if.ready);
		book.note_word(cmd, who);
		@(negedge clk);
	endtask

	// Drain the block, then write the active count and read it back.
	task automatic set_active(input logic [5:0] value);
		req_if.valid = 1'b0;
		while (book.pending_grants.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = bta_pkg::PADDR_W'(4 * bta_pkg::REG_ACTIVE);
		pwdata = {26'd0, value};
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		book.active_reg = value;
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== {26'd0, value}) begin
			book.mismatches++;
			$display("%0t: active_requesters readback expected %0d actual %0d", $time,
				value, prdata);
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic random_words(input int count);
		int unsigned n;
		int i;
		bta_pkg::cmd_t c;
		bta_pkg::requester_t r;
		for (i = 0; i < count; i++) begin
			n = book.live_count();
			// mostly requesters that take part, some from the full range, which may lie beyond the active count
			if ($urandom_range(99) < 85)
				r = 5'($urandom_range(n - 1));
			else
				r = 5'($urandom_range(31));
			c = ($urandom_range(99) < 40) ? bta_pkg::CMD_RELEASE : bta_pkg::CMD_REQUEST;
			send_word(c, r);
		end
	endtask

	initial begin
		int phase;
		logic [5:0] phase_active [8];

		book = new();
		phase_active = '{6'd32, 6'd1, 6'd63, 6'd0, 6'd2, 6'd17, 6'd32, 6'd5};
		set_idling(0);
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_if.valid = 1'b0;
		req_if.cmd = bta_pkg::CMD_REQUEST;
		req_if.requester = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty release, re-request, holder hand-over
		send_word(bta_pkg::CMD_RELEASE, 5'd0);
		send_word(bta_pkg::CMD_REQUEST, 5'd0);
		send_word(bta_pkg::CMD_REQUEST, 5'd31);
		send_word(bta_pkg::CMD_REQUEST, 5'd5);
		send_word(bta_pkg::CMD_REQUEST, 5'd0);
		send_word(bta_pkg::CMD_RELEASE, 5'd31);
		send_word(bta_pkg::CMD_REQUEST, 5'd31);
		send_word(bta_pkg::CMD_RELEASE, 5'd5);
		send_word(bta_pkg::CMD_RELEASE, 5'd0);
		send_word(bta_pkg::CMD_RELEASE, 5'd31);
		// hidden entry survives a shrink and ties on regrowth
		send_word(bta_pkg::CMD_REQUEST, 5'd20);
		set_active(6'd4);
		send_word(bta_pkg::CMD_REQUEST, 5'd1);
		send_word(bta_pkg::CMD_RELEASE, 5'd20);
		send_word(bta_pkg::CMD_REQUEST, 5'd31);
		set_active(6'd32);
		send_word(bta_pkg::CMD_REQUEST, 5'd2);
		send_word(bta_pkg::CMD_RELEASE, 5'd1);
		send_word(bta_pkg::CMD_RELEASE, 5'd20);
		send_word(bta_pkg::CMD_RELEASE, 5'd2);
		// zero count acts as one, oversize count clamps
		set_active(6'd0);
		send_word(bta_pkg::CMD_REQUEST, 5'd1);
		send_word(bta_pkg::CMD_REQUEST, 5'd0);
		send_word(bta_pkg::CMD_RELEASE, 5'd0);
		set_active(6'd63);
		send_word(bta_pkg::CMD_REQUEST, 5'd31);
		send_word(bta_pkg::CMD_RELEASE, 5'd31);

		for (phase = 0; phase < 8; phase++) begin
			set_active(phase == 7 ? 6'($urandom_range(63)) : phase_active[phase]);
			set_idling(phase % 4);
			random_words(70);
		end

		set_active(6'd32);
		set_idling(3);
		send_word(bta_pkg::CMD_REQUEST, 5'd7);
		send_word(bta_pkg::CMD_REQUEST, 5'd0);
		send_word(bta_pkg::CMD_RELEASE, 5'd0);
		send_word(bta_pkg::CMD_RELEASE, 5'd7);
		random_words(20);

		req_if.valid = 1'b0;
		while (book.pending_grants.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (book.mismatches == 0 && book.pending_grants.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/bta_pkg.sv
hw/rtl/bta_if.sv
hw/rtl/bakery_ticket_arbiter.sv
sim/tb_bakery_ticket_arbiter.sv
